/* src/ffi_pkg.sv */
// Shared types, widths and constants for the fault signal filter interlock.
package ffi_pkg;

    // Window depth and sample width
    localparam int WINDOW      = 5;
    localparam int SAMPLE_BITS = 12;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // Window sum and exact divide-by-WINDOW via reciprocal multiply
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIV_SHIFT   = SUM_BITS + $clog2(WINDOW);
    localparam int RECIP_BITS  = DIV_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] DIV_RECIP =
        RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Input draw fields
    localparam int NOISE_BITS = 5;
    localparam int CRASH_BITS = 4;
    localparam logic [NOISE_BITS-1:0] NOISE_MOD    = NOISE_BITS'(20);
    localparam logic [NOISE_BITS-1:0] NOISE_OFFSET = NOISE_BITS'(10);
    localparam logic [CRASH_BITS-1:0] CRASH_MOD    = CRASH_BITS'(10);
    localparam logic [CRASH_BITS-1:0] CRASH_PICK   = CRASH_BITS'(7);

    // Tick counter saturates at all ones
    localparam int TICK_BITS = 17;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Register widths
    localparam int LEN_BITS    = 8;
    localparam int CRUISE_BITS = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASELINE  = 3'd0,
        CFG_SPIKE     = 3'd1,
        CFG_CRASH     = 3'd2,
        CFG_THRESHOLD = 3'd3,
        CFG_CRUISE_T  = 3'd4,
        CFG_SPIKE_T   = 3'd5,
        CFG_CRASH_T   = 3'd6
    } t_cfg_idx;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] RST_BASELINE  = SAMPLE_BITS'(1000);
    localparam logic [SAMPLE_BITS-1:0] RST_SPIKE     = SAMPLE_BITS'(2500);
    localparam logic [SAMPLE_BITS-1:0] RST_CRASH     = SAMPLE_BITS'(300);
    localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD = SAMPLE_BITS'(500);
    localparam logic [CRUISE_BITS-1:0] RST_CRUISE_T  = CRUISE_BITS'(2000);
    localparam logic [LEN_BITS-1:0]    RST_SPIKE_T   = LEN_BITS'(5);
    localparam logic [LEN_BITS-1:0]    RST_CRASH_T   = LEN_BITS'(50);

    typedef enum logic [1:0] {
        PH_CRUISE = 2'd0,
        PH_SPIKE  = 2'd1,
        PH_CRASH  = 2'd2
    } t_phase;

    // Injector settings bundle
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] baseline_level;
        logic [SAMPLE_BITS-1:0] spike_level;
        logic [SAMPLE_BITS-1:0] crash_level;
        logic [CRUISE_BITS-1:0] cruise_ticks;
        logic [LEN_BITS-1:0]    spike_ticks;
        logic [LEN_BITS-1:0]    crash_ticks;
    } t_inj_cfg;

endpackage

/* src/ffi_in_if.sv */
// Input channel: random draws for one tick.
interface ffi_in_if import ffi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [NOISE_BITS-1:0] noise_draw;
    logic [CRASH_BITS-1:0] crash_draw;

    modport source (output valid, output noise_draw, output crash_draw, input ready);
    modport sink   (input valid, input noise_draw, input crash_draw, output ready);
endinterface

/* src/ffi_out_if.sv */
// Output channel: raw and filtered sample, stop flag and phase for one tick.
interface ffi_out_if import ffi_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic [SAMPLE_BITS-1:0] filtered_sample;
    logic                   emergency_stop;
    logic [1:0]             phase;

    modport source (output valid, output raw_sample, output filtered_sample,
                    output emergency_stop, output phase, input ready);
    modport sink   (input valid, input raw_sample, input filtered_sample,
                    input emergency_stop, input phase, output ready);
endinterface

/* src/ffi_injector.sv */
// Three-phase fault injector: phase and tick state, level select, noise and saturation.
module ffi_injector import ffi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  t_inj_cfg               i_cfg,
    input  logic [NOISE_BITS-1:0]  i_noise_draw,
    input  logic [CRASH_BITS-1:0]  i_crash_draw,
    output logic [SAMPLE_BITS-1:0] o_raw,
    output t_phase                 o_phase
);

    t_phase                 r_phase, n_phase, mid_phase;
    logic [TICK_BITS-1:0]   r_tick, n_tick, tick_inc;
    logic [NOISE_BITS-1:0]  noise_sel;
    logic [CRASH_BITS-1:0]  crash_sel;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS:0]   level_sum;
    logic [SAMPLE_BITS:0]   level_dif;

    always_comb begin
        noise_sel = (i_noise_draw >= NOISE_MOD) ? i_noise_draw - NOISE_MOD : i_noise_draw;
        crash_sel = (i_crash_draw >= CRASH_MOD) ? i_crash_draw - CRASH_MOD : i_crash_draw;
        tick_inc  = (r_tick == TICK_MAX) ? r_tick : r_tick + 1'b1;

        // leave cruise once the count passes its length
        mid_phase = r_phase;
        n_tick    = tick_inc;
        case (r_phase)
            PH_CRUISE: begin
                if (tick_inc > TICK_BITS'(i_cfg.cruise_ticks)) begin
                    n_tick    = '0;
                    mid_phase = (crash_sel > CRASH_PICK) ? PH_CRASH : PH_SPIKE;
                end
            end
            default: ;
        endcase

        // level follows the current phase; a finished fault drops back to cruise
        n_phase = mid_phase;
        case (mid_phase)
            PH_SPIKE: begin
                level = i_cfg.spike_level;
                if (n_tick > TICK_BITS'(i_cfg.spike_ticks)) begin
                    n_phase = PH_CRUISE;
                    n_tick  = '0;
                end
            end
            PH_CRASH: begin
                level = i_cfg.crash_level;
                if (n_tick > TICK_BITS'(i_cfg.crash_ticks)) begin
                    n_phase = PH_CRUISE;
                    n_tick  = '0;
                end
            end
            default: begin
                level   = i_cfg.baseline_level;
                n_phase = PH_CRUISE;
            end
        endcase

        // level + draw - offset, clamped to the sample range
        level_sum = {1'b0, level} + (SAMPLE_BITS+1)'(noise_sel);
        level_dif = level_sum - (SAMPLE_BITS+1)'(NOISE_OFFSET);
        if (level_sum < (SAMPLE_BITS+1)'(NOISE_OFFSET)) begin
            o_raw = '0;
        end else if (level_dif > {1'b0, SAMPLE_MAX}) begin
            o_raw = SAMPLE_MAX;
        end else begin
            o_raw = level_dif[SAMPLE_BITS-1:0];
        end
        o_phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CRUISE;
            r_tick  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
        end
    end

endmodule

/* src/ffi_cell.sv */
// One window cell: holds a sample, passes it on, adds it to the running partial sum.
module ffi_cell import ffi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SUM_BITS-1:0]    i_partial,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic [SUM_BITS-1:0]    o_partial
);

    logic [SAMPLE_BITS-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample  = r_sample;
    assign o_partial = i_partial + SUM_BITS'(r_sample);

endmodule

/* src/ffi_filter.sv */
// Row of window cells, mean by reciprocal multiply, and threshold compare.
module ffi_filter import ffi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_raw,
    input  logic [SAMPLE_BITS-1:0] i_threshold,
    output logic [SAMPLE_BITS-1:0] o_filtered,
    output logic                   o_stop
);

    logic [SAMPLE_BITS-1:0] samp [WINDOW+1];
    logic [SUM_BITS-1:0]    part [WINDOW+1];
    logic [PROD_BITS-1:0]   prod;

    assign samp[0] = i_raw;
    assign part[0] = '0;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        ffi_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (i_shift),
            .i_sample  (samp[g]),
            .i_partial (part[g]),
            .o_sample  (samp[g+1]),
            .o_partial (part[g+1])
        );
    end

    // last cell's sample falls off the end of the window
    always_comb begin
        prod       = PROD_BITS'(part[WINDOW]) * PROD_BITS'(DIV_RECIP);
        o_filtered = prod[DIV_SHIFT +: SAMPLE_BITS];
        o_stop     = (o_filtered < i_threshold) || (samp[WINDOW] != samp[WINDOW]);
    end

endmodule

/* src/fault_signal_filter_interlock_core.sv */
// Top level: fault injector, five-cell averaging window and emergency-stop interlock.
//
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+------------------------------------------------
//  i_in     | in  | valid/ready      | noise_draw[4:0], crash_draw[3:0]
//  o_out    | out | valid/ready      | raw_sample, filtered_sample, emergency_stop, phase
//  i_cfg_*  | in  | write enable     | register index [2:0], data [15:0]
//
// One word per cycle, sustained while o_out.ready stays high. A word is registered
// in the injector stage (phase update, sample and window shift) and then in the
// output register on o_out, after the window sum and reciprocal multiply.
// Reset (i_rst_n low at a clock edge) restores register defaults, cruise phase,
// a zero tick count and an all-zero window; no clearing pass is needed.
// A stalled output holds its word; the injector stage still takes one more word
// and then holds, so i_in.ready drops only while both stages are full.
module fault_signal_filter_interlock_core import ffi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ffi_in_if.sink                   i_in,
    ffi_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // configuration registers
    t_inj_cfg               r_cfg;
    logic [SAMPLE_BITS-1:0] r_threshold;

    // injector stage: holds the sample whose window sum is now in the cells
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_raw;
    t_phase                 r_s1_phase;

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_raw;
    logic [SAMPLE_BITS-1:0] r_out_filtered;
    logic                   r_out_stop;
    t_phase                 r_out_phase;

    logic                   in_take;
    logic                   s1_adv;
    logic [SAMPLE_BITS-1:0] inj_raw;
    t_phase                 inj_phase;
    logic [SAMPLE_BITS-1:0] filt_value;
    logic                   filt_stop;

    // advance the injector stage when the output register is free or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baseline_level <= RST_BASELINE;
            r_cfg.spike_level    <= RST_SPIKE;
            r_cfg.crash_level    <= RST_CRASH;
            r_cfg.cruise_ticks   <= RST_CRUISE_T;
            r_cfg.spike_ticks    <= RST_SPIKE_T;
            r_cfg.crash_ticks    <= RST_CRASH_T;
            r_threshold          <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASELINE:  r_cfg.baseline_level <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_SPIKE:     r_cfg.spike_level    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_CRASH:     r_cfg.crash_level    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_THRESHOLD: r_threshold          <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_CRUISE_T:  r_cfg.cruise_ticks   <= i_cfg_data[CRUISE_BITS-1:0];
                CFG_SPIKE_T:   r_cfg.spike_ticks    <= i_cfg_data[LEN_BITS-1:0];
                CFG_CRASH_T:   r_cfg.crash_ticks    <= i_cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    ffi_injector u_injector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_take),
        .i_cfg        (r_cfg),
        .i_noise_draw (i_in.noise_draw),
        .i_crash_draw (i_in.crash_draw),
        .o_raw        (inj_raw),
        .o_phase      (inj_phase)
    );

    // the window shifts with each accepted word; the sum read out belongs to
    // the word held in the injector stage
    ffi_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (in_take),
        .i_raw       (inj_raw),
        .i_threshold (r_threshold),
        .o_filtered  (filt_value),
        .o_stop      (filt_stop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_raw   <= inj_raw;
            r_s1_phase <= inj_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_raw      <= r_s1_raw;
            r_out_filtered <= filt_value;
            r_out_stop     <= filt_stop;
            r_out_phase    <= r_s1_phase;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.raw_sample      = r_out_raw;
    assign o_out.filtered_sample = r_out_filtered;
    assign o_out.emergency_stop  = r_out_stop;
    assign o_out.phase           = r_out_phase;

endmodule

/* tb/fault_signal_filter_interlock_checker.sv */
// Checker for the fault signal filter interlock: tick predictor, word scoreboard and counters.
module fault_signal_filter_interlock_checker import ffi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ffi_in_if                        i_in,
    ffi_out_if                       i_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_words,
    output int                       o_stop_words,
    output int                       o_spike_words,
    output int                       o_crash_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NOISE_SPAN   = 20;
    localparam int NOISE_CENTER = 10;
    localparam int CRASH_SPAN   = 10;
    localparam int CRASH_CUT    = 7;
    localparam int SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw;
        logic [SAMPLE_BITS-1:0] filt;
        logic                   stop;
        logic [1:0]             phase;
    } t_tick_word;

    t_inj_cfg               inj_cfg;
    logic [SAMPLE_BITS-1:0] stop_thr;
    t_phase                 phase_q;
    logic [TICK_BITS-1:0]   tick_q;
    logic [SAMPLE_BITS-1:0] window_q [WINDOW];
    int                     slot_q;
    t_tick_word             expected_words [$];

    // Advance the injector and averaging window by one tick.
    function automatic t_tick_word advance_injector(input logic [NOISE_BITS-1:0] nd,
                                                    input logic [CRASH_BITS-1:0] cd);
        int         noise_sel;
        int         crash_sel;
        int         level_v;
        int         sample_v;
        int         sum_v;
        t_tick_word w;
        noise_sel = int'(nd) % NOISE_SPAN;
        crash_sel = int'(cd) % CRASH_SPAN;
        if (phase_q != PH_SPIKE && phase_q != PH_CRASH) phase_q = PH_CRUISE;
        if (tick_q != {TICK_BITS{1'b1}}) tick_q = tick_q + 1'b1;
        if (phase_q == PH_CRUISE && tick_q > inj_cfg.cruise_ticks) begin
            phase_q = (crash_sel > CRASH_CUT) ? PH_CRASH : PH_SPIKE;
            tick_q  = '0;
        end
        // Level comes from the phase in force; the phase may end after it is taken.
        case (phase_q)
            PH_SPIKE: begin
                level_v = int'(inj_cfg.spike_level);
                if (tick_q > inj_cfg.spike_ticks) begin
                    phase_q = PH_CRUISE;
                    tick_q  = '0;
                end
            end
            PH_CRASH: begin
                level_v = int'(inj_cfg.crash_level);
                if (tick_q > inj_cfg.crash_ticks) begin
                    phase_q = PH_CRUISE;
                    tick_q  = '0;
                end
            end
            default: level_v = int'(inj_cfg.baseline_level);
        endcase
        sample_v = level_v + noise_sel - NOISE_CENTER;
        if (sample_v < 0) sample_v = 0;
        else if (sample_v > SAMPLE_TOP) sample_v = SAMPLE_TOP;
        w.raw = SAMPLE_BITS'(sample_v);
        window_q[slot_q] = w.raw;
        slot_q = (slot_q + 1) % WINDOW;
        sum_v = 0;
        for (int i = 0; i < WINDOW; i++) sum_v += int'(window_q[i]);
        w.filt  = SAMPLE_BITS'(sum_v / WINDOW);
        w.stop  = (w.filt < stop_thr);
        w.phase = phase_q;
        return w;
    endfunction

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_words
        t_tick_word want_w;
        if (!i_rst_n) begin
            inj_cfg.baseline_level = 12'd1000;
            inj_cfg.spike_level    = 12'd2500;
            inj_cfg.crash_level    = 12'd300;
            inj_cfg.cruise_ticks   = 16'd2000;
            inj_cfg.spike_ticks    = 8'd5;
            inj_cfg.crash_ticks    = 8'd50;
            stop_thr      = 12'd500;
            phase_q       = PH_CRUISE;
            tick_q        = '0;
            slot_q        = 0;
            for (int i = 0; i < WINDOW; i++) window_q[i] = '0;
            expected_words.delete();
            o_fail_count  = 0;
            o_words       = 0;
            o_stop_words  = 0;
            o_spike_words = 0;
            o_crash_words = 0;
        end else begin
            // Compare first: a word leaving now belongs to an older tick.
            if (i_out.valid && i_out.ready) begin
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: word raw=%0d filt=%0d stop=%0d phase=%0d with none expected",
                             $time, i_out.raw_sample, i_out.filtered_sample,
                             i_out.emergency_stop, i_out.phase);
                end else begin
                    want_w = expected_words.pop_front();
                    compare_field("raw_sample", want_w.raw, i_out.raw_sample);
                    compare_field("filtered_sample", want_w.filt, i_out.filtered_sample);
                    compare_field("emergency_stop", want_w.stop, i_out.emergency_stop);
                    compare_field("phase", want_w.phase, i_out.phase);
                    o_words++;
                    if (want_w.stop) o_stop_words++;
                    if (want_w.phase == PH_SPIKE) o_spike_words++;
                    if (want_w.phase == PH_CRASH) o_crash_words++;
                end
            end
            if (i_in.valid && i_in.ready)
                expected_words.push_back(advance_injector(i_in.noise_draw, i_in.crash_draw));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASELINE:  inj_cfg.baseline_level = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_SPIKE:     inj_cfg.spike_level    = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_CRASH:     inj_cfg.crash_level    = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_THRESHOLD: stop_thr               = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_CRUISE_T:  inj_cfg.cruise_ticks   = i_cfg_data[CRUISE_BITS-1:0];
                    CFG_SPIKE_T:   inj_cfg.spike_ticks    = i_cfg_data[LEN_BITS-1:0];
                    CFG_CRASH_T:   inj_cfg.crash_ticks    = i_cfg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_words.size();
    end

endmodule

/* tb/fault_signal_filter_interlock_core_tb.sv */
// Testbench top for the fault signal filter interlock: stimulus, stalls and verdict.
module fault_signal_filter_interlock_core_tb import ffi_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT      = 26;
    localparam int HOLD_CYCLES   = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_SETS   = 13;
    localparam int WORDS_PER_SET = 130;
    localparam int DIRECTED      = 25;

    logic                     clk     = 1'b0;
    logic                     rst_n   = 1'b0;
    logic                     cfg_we  = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int words;
    int stop_words;
    int spike_words;
    int crash_words;

    // Set while a settings group runs with no idling on either side.
    bit quiet_run   = 1'b0;
    // The receiver serves one long hold-off per ask.
    int hold_asks   = 0;
    int hold_served = 0;
    int idle_cycles = 0;

    // Directed draws: extremes of both fields, out-of-range values reduced
    // by the modulo stage, and both sides of the crash pick.
    int dir_noise [DIRECTED] = '{0, 19, 31, 20, 9, 10, 16, 4, 8,
                                 19, 19, 0, 31, 0, 19, 5, 12,
                                 0, 19, 31, 10, 3, 17, 9, 0};
    int dir_crash [DIRECTED] = '{0, 9, 15, 8, 7, 1, 2, 4, 8,
                                 9, 0, 7, 8, 15, 3, 9, 12,
                                 8, 9, 0, 15, 7, 10, 9, 1};

    ffi_in_if  in_ch ();
    ffi_out_if out_ch ();

    always #5 clk = ~clk;

    fault_signal_filter_interlock_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fault_signal_filter_interlock_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_words       (words),
        .o_stop_words  (stop_words),
        .o_spike_words (spike_words),
        .o_crash_words (crash_words)
    );

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request so that
    // both stages fill and the block drops its input ready.
    initial begin : receiver
        int held;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_asks != hold_served) begin
                hold_served++;
                out_ch.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
            end else if (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one word after a random idle run; return at the falling edge
    // after it is taken, with valid still high.
    task automatic send_word(input logic [NOISE_BITS-1:0] nd, input logic [CRASH_BITS-1:0] cd);
        while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.noise_draw <= nd;
        in_ch.crash_draw <= cd;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every word of the group has come out.
    // Each tick makes exactly one word, so a short margin covers the pipe.
    task automatic finish_group();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_BITS'(value);
        @(negedge clk);
    endtask

    // Write all seven registers back to back; the block is idle here.
    task automatic load_settings(input int base, input int spk, input int crs, input int thr,
                                 input int cruise, input int spk_len, input int crs_len);
        write_reg(CFG_BASELINE, base);
        write_reg(CFG_SPIKE, spk);
        write_reg(CFG_CRASH, crs);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_CRUISE_T, cruise);
        write_reg(CFG_SPIKE_T, spk_len);
        write_reg(CFG_CRASH_T, crs_len);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Zero or the field maximum now and then, else a value up to typical.
    function automatic int pick_span(input int top, input int typical);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    initial begin : stimulus
        int set_idx;
        int n;
        logic [NOISE_BITS-1:0] nd;
        logic [CRASH_BITS-1:0] cd;
        in_ch.valid      = 1'b0;
        in_ch.noise_draw = '0;
        in_ch.crash_draw = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. First group runs on the reset settings; the next two
        // use extreme levels with short phases so that cruise, spike
        // and crash alternate quickly and samples saturate at both ends.
        for (n = 0; n < DIRECTED; n++) begin
            if (n == 9) begin
                finish_group();
                load_settings(4095, 0, 4095, 0, 0, 0, 0);
            end else if (n == 17) begin
                finish_group();
                load_settings(0, 4095, 0, 4095, 1, 2, 1);
            end
            send_word(NOISE_BITS'(dir_noise[n]), CRASH_BITS'(dir_crash[n]));
        end
        finish_group();

        // Random groups: fresh settings each time, mostly short phases so that
        // the injector cycles often; a new length may cut a running phase.
        for (set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            quiet_run = (set_idx == 5);
            load_settings(pick_span(4095, 4095), pick_span(4095, 4095),
                          pick_span(4095, 4095), pick_span(4095, 4095),
                          pick_span(65535, 40), pick_span(255, 25), pick_span(255, 25));
            for (n = 0; n < WORDS_PER_SET; n++) begin
                if (set_idx == 3 && n == 40) hold_asks++;
                nd = ($urandom_range(0, 99) < 85) ? NOISE_BITS'($urandom_range(0, 19))
                                                  : NOISE_BITS'($urandom_range(0, 31));
                cd = ($urandom_range(0, 99) < 85) ? CRASH_BITS'($urandom_range(0, 9))
                                                  : CRASH_BITS'($urandom_range(0, 15));
                send_word(nd, cd);
            end
            finish_group();
        end
        quiet_run = 1'b0;

        $display("Run covered %0d words over %0d register settings, with a %0d-cycle output hold-off.",
                 words, RANDOM_SETS + 3, HOLD_CYCLES);
        $display("Spike words %0d, crash words %0d, emergency stop raised on %0d words.",
                 spike_words, crash_words, stop_words);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* fault_signal_filter_interlock_core.f */
src/ffi_pkg.sv
src/ffi_in_if.sv
src/ffi_out_if.sv
src/ffi_injector.sv
src/ffi_cell.sv
src/ffi_filter.sv
src/fault_signal_filter_interlock_core.sv
tb/fault_signal_filter_interlock_checker.sv
tb/fault_signal_filter_interlock_core_tb.sv
